### rtl/modulo_reservation_table_defines.svh
`ifndef MODULO_RESERVATION_TABLE_DEFINES_SVH
`define MODULO_RESERVATION_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define MRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MRT_ASSERT_NOW(lbl, ante, cons)
`define MRT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/mrt_pkg.sv
package mrt_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int NSLOT     = MAX_SLOTS + 1;
  localparam int SLOT_AW   = $clog2(NSLOT);
  localparam int SUM_W     = 18;

  localparam logic [1:0] FUNC_OP    = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_STORE = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  localparam logic [1:0] PATH_NONE  = 2'd0;
  localparam logic [1:0] PATH_TRUE  = 2'd1;
  localparam logic [1:0] PATH_FALSE = 2'd2;
  localparam logic [1:0] PATH_BAD   = 2'd3;

  localparam logic [2:0] REG_ROWS   = 3'd0;
  localparam logic [2:0] REG_COLS   = 3'd1;
  localparam logic [2:0] REG_BUSES  = 3'd2;
  localparam logic [2:0] REG_II     = 3'd3;
  localparam logic [2:0] REG_SLEN   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_SCAN, S_WR1, S_WR2, S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0][8:0] elem;
    logic [2:0][6:0] abus;
    logic [2:0][6:0] dbus;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [9:0] merge_cnt(input logic [8:0] c0, input logic [8:0] c1,
                                           input logic [8:0] c2, input logic [1:0] p);
    logic [8:0] mx;
    mx = (c1 > c2) ? c1 : c2;
    if (p == PATH_NONE) return {1'b0, c0} + {1'b0, mx};
    else if (p == PATH_TRUE) return {1'b0, c0} + {1'b0, c1};
    else return {1'b0, c0} + {1'b0, c2};
  endfunction

  function automatic logic [8:0] sat_elem(input logic [8:0] c, input logic [1:0] amt);
    logic [9:0] s;
    s = {1'b0, c} + {8'd0, amt};
    return s[9] ? 9'h1FF : s[8:0];
  endfunction

  function automatic logic [6:0] sat_bus(input logic [6:0] c);
    return (c == 7'h7F) ? c : c + 7'd1;
  endfunction

endpackage

### rtl/mrt_ram.sv
module mrt_ram #(
  parameter int DEPTH = 65,
  parameter int WIDTH = 69
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/modulo_reservation_table.sv
// Flow: residue division (S_DIV), scan of the counters (S_SCAN), write (S_WR1), then result (S_DONE),
// with a second write (S_WR2) for a granted load; clear and bad-path requests skip the scan.
// Throughput: one request at a time, limited by the residue division
// loop and the one-entry-per-cycle scan of the single-port counter memory.
// Reset: synchronous; configuration returns to its defaults and all counters read as zero.
`include "modulo_reservation_table_defines.svh"

module modulo_reservation_table (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [1:0] path,
  input  logic [5:0] time_req,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       granted,
  output logic [5:0] first_slot,
  output logic [5:0] second_slot,
  output logic [5:0] iteration,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [6:0] cfg_data
);
  import mrt_pkg::*;

  state_t state, state_next;

  logic [4:0] rows, cols;
  logic [2:0] buses_per_row;
  logic [6:0] interval, sched_length;

  logic [1:0] r_func, r_path;
  logic [5:0] r_t;
  logic [6:0] rem, quo, u, ru, u_d, ru_d, last;
  logic       pend, vld_d, zero_d, ok;
  logic [NSLOT-1:0] vld;
  logic [SUM_W-1:0] e1, a1, d1, e2, d2;
  entry_t ent1, ent2, rd_ent, eff, wr_ent;

  logic [6:0] ii, r2, t1, t2;
  logic [SLOT_AW-1:0] addr;
  logic we, ok_comb, in1, in2, c1, c2;
  logic [9:0] pe_lim, me_p, me_0, ma_p, ma_0, md_p, md_0;
  logic [7:0] bus_lim;
  logic [ENTRY_W-1:0] rdata;

  assign ii      = (interval == 7'd0) ? 7'd1 : interval;
  assign r2      = (rem + 7'd1 == ii) ? 7'd0 : rem + 7'd1;
  assign t1      = {1'b0, r_t};
  assign t2      = t1 + 7'd1;
  assign pe_lim  = {5'd0, rows} * {5'd0, cols};
  assign bus_lim = {5'd0, buses_per_row} * {3'd0, rows};
  assign in_ready = (state == S_IDLE);
  assign rd_ent  = entry_t'(rdata);
  assign eff     = (vld_d && !zero_d) ? rd_ent : '0;

  assign me_p = merge_cnt(eff.elem[0], eff.elem[1], eff.elem[2], r_path);
  assign me_0 = merge_cnt(eff.elem[0], eff.elem[1], eff.elem[2], PATH_NONE);
  assign ma_p = merge_cnt({2'd0, eff.abus[0]}, {2'd0, eff.abus[1]}, {2'd0, eff.abus[2]}, r_path);
  assign ma_0 = merge_cnt({2'd0, eff.abus[0]}, {2'd0, eff.abus[1]}, {2'd0, eff.abus[2]},
                          PATH_NONE);
  assign md_p = merge_cnt({2'd0, eff.dbus[0]}, {2'd0, eff.dbus[1]}, {2'd0, eff.dbus[2]}, r_path);
  assign md_0 = merge_cnt({2'd0, eff.dbus[0]}, {2'd0, eff.dbus[1]}, {2'd0, eff.dbus[2]},
                          PATH_NONE);

  assign in1 = (u_d == t1);
  assign in2 = (u_d == t2);
  assign c1  = (u_d < sched_length) && (ru_d == rem) && !in1;
  assign c2  = (u_d < sched_length) && (ru_d == r2) && !in2;

  always_comb begin
    case (r_func)
      FUNC_OP:    ok_comb = e1 < SUM_W'(pe_lim);
      FUNC_LOAD:  ok_comb = (a1 < SUM_W'(bus_lim)) && (d2 < SUM_W'(bus_lim)) &&
                            (e1 < SUM_W'(pe_lim)) && (e2 < SUM_W'(pe_lim));
      FUNC_STORE: ok_comb = (a1 < SUM_W'(bus_lim)) && (d1 < SUM_W'(bus_lim)) &&
                            (e1 + SUM_W'(1) < SUM_W'(pe_lim));
      default:    ok_comb = 1'b0;
    endcase
  end

  always_comb begin
    wr_ent = ent1;
    if (state == S_WR2) begin
      wr_ent = ent2;
      wr_ent.dbus[r_path] = sat_bus(ent2.dbus[r_path]);
      wr_ent.elem[r_path] = sat_elem(ent2.elem[r_path], 2'd1);
    end else begin
      case (r_func)
        FUNC_LOAD: begin
          wr_ent.abus[r_path] = sat_bus(ent1.abus[r_path]);
          wr_ent.elem[r_path] = sat_elem(ent1.elem[r_path], 2'd1);
        end
        FUNC_STORE: begin
          wr_ent.abus[r_path] = sat_bus(ent1.abus[r_path]);
          wr_ent.dbus[r_path] = sat_bus(ent1.dbus[r_path]);
          wr_ent.elem[r_path] = sat_elem(ent1.elem[r_path], 2'd2);
        end
        default: wr_ent.elem[r_path] = sat_elem(ent1.elem[r_path], 2'd1);
      endcase
    end
  end

  always_comb begin
    we   = 1'b0;
    addr = SLOT_AW'(u);
    case (state)
      S_WR1: begin
        we   = ok_comb;
        addr = SLOT_AW'(t1);
      end
      S_WR2: begin
        we   = 1'b1;
        addr = SLOT_AW'(t2);
      end
      default: ;
    endcase
  end

  mrt_ram #(.DEPTH(NSLOT), .WIDTH(ENTRY_W)) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wr_ent),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DIV;
      S_DIV: begin
        if (rem < ii) begin
          state_next = (r_func == FUNC_CLEAR || r_path == PATH_BAD) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: if (u >= last && !pend) state_next = S_WR1;
      S_WR1:  state_next = (ok_comb && r_func == FUNC_LOAD) ? S_WR2 : S_DONE;
      S_WR2:  state_next = S_DONE;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows          <= 5'd4;
      cols          <= 5'd4;
      buses_per_row <= 3'd1;
      interval      <= 7'd1;
      sched_length  <= 7'd1;
      vld           <= '0;
      out_valid     <= 1'b0;
      pend          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS:  rows          <= cfg_data[4:0];
          REG_COLS:  cols          <= cfg_data[4:0];
          REG_BUSES: buses_per_row <= cfg_data[2:0];
          REG_II:    interval      <= cfg_data;
          REG_SLEN:  sched_length  <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (we) vld[addr] <= 1'b1;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_func <= func;
            r_path <= path;
            r_t    <= time_req;
            rem    <= {1'b0, time_req};
            quo    <= 7'd0;
            ok     <= 1'b0;
            if (func == FUNC_CLEAR) vld <= '0;
          end
        end
        S_DIV: begin
          if (rem >= ii) begin
            rem <= rem - ii;
            quo <= quo + 7'd1;
          end else begin
            u    <= 7'd0;
            ru   <= 7'd0;
            pend <= 1'b0;
            last <= (sched_length > t1 + 7'd2) ? sched_length : t1 + 7'd2;
            e1 <= '0; a1 <= '0; d1 <= '0; e2 <= '0; d2 <= '0;
          end
        end
        S_SCAN: begin
          pend <= (u < last);
          if (u < last) begin
            u      <= u + 7'd1;
            ru     <= (ru + 7'd1 == ii) ? 7'd0 : ru + 7'd1;
            u_d    <= u;
            ru_d   <= ru;
            zero_d <= (u > 7'(MAX_SLOTS));
            vld_d  <= vld[addr];
          end
          if (pend) begin
            if (in1) begin
              e1 <= e1 + SUM_W'(me_p); a1 <= a1 + SUM_W'(ma_p); d1 <= d1 + SUM_W'(md_p);
              ent1 <= eff;
            end else if (c1) begin
              e1 <= e1 + SUM_W'(me_0); a1 <= a1 + SUM_W'(ma_0); d1 <= d1 + SUM_W'(md_0);
            end
            if (in2) begin
              e2 <= e2 + SUM_W'(me_p); d2 <= d2 + SUM_W'(md_p);
              ent2 <= eff;
            end else if (c2) begin
              e2 <= e2 + SUM_W'(me_0); d2 <= d2 + SUM_W'(md_0);
            end
          end
        end
        S_WR1: ok <= ok_comb;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            granted     <= ok;
            first_slot  <= rem[5:0];
            second_slot <= r2[5:0];
            iteration   <= quo[5:0];
          end
        end
        default: ;
      endcase
    end
  end

  `MRT_ASSERT_NEXT(a_accept_div, in_valid && in_ready, state == S_DIV)
  `MRT_ASSERT_NOW(a_write_phase, we, state == S_WR1 || state == S_WR2)
  `MRT_ASSERT_NEXT(a_load_second, state == S_WR1 && ok_comb && r_func == FUNC_LOAD,
                   state == S_WR2)

endmodule
